// File: src/ook_manchester_pulse_decoder_macros.svh
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef OOK_MANCHESTER_PULSE_DECODER_MACROS_SVH
`define OOK_MANCHESTER_PULSE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside of reset.
`define OOKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define OOKM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OOKM_ASSERT(lbl, prop, msg)
`define OOKM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: src/ookm_pkg.sv
`default_nettype none

package ookm_pkg;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_BIT    = 2'd1,
    PH_SHORT  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    OP_PULSE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PULSE         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_THRESHOLD    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PULSE         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_WIDTH         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PREAMBLE_NEEDED   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_MESSAGE_BYTES = 3'd5;

  typedef struct packed {
    logic [15:0] min_pulse;
    logic [15:0] long_threshold;
    logic [15:0] max_pulse;
    logic [15:0] gap_width;
    logic [7:0]  preamble_needed;
    logic [5:0]  min_message_bytes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_pulse:         16'd200,
    long_threshold:    16'd700,
    max_pulse:         16'd1200,
    gap_width:         16'd2500,
    preamble_needed:   8'd24,
    min_message_bytes: 6'd8
  };

  // Status reported with every transaction, taken after the item's update.
  typedef struct packed {
    logic       done;
    logic [5:0] byte_count;
    phase_t     state;
  } status_t;

  // What one item asks of the byte store.
  typedef struct packed {
    logic shift;  // shift one bit into the byte at the address
    logic rd;     // return the byte at the address
    logic bit_in; // bit that enters at the top of the byte
  } store_req_t;

endpackage

`default_nettype wire

// File: src/ookm_ctrl.sv
`default_nettype none
`include "ook_manchester_pulse_decoder_macros.svh"

module ookm_ctrl
  import ookm_pkg::*;
#(
  parameter int BUFFER_BYTES = 32,
  localparam int HBC_W = $clog2(BUFFER_BYTES * 16),
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          accept,
  input  wire logic [1:0]    opcode,
  input  wire logic [15:0]   pulse_width,
  input  wire logic [4:0]    byte_index,
  output status_t            status_next,
  output store_req_t         req,
  output logic [AW-1:0]      addr
);

  phase_t             phase, phase_next;
  logic [7:0]         fop, fop_next;
  logic [HBC_W-1:0]   hbc, hbc_next;

  logic               width_ok;
  logic               is_long;
  logic               is_gap;
  logic               preamble_ok;
  logic               overflow;
  logic               in_range;
  logic [5:0]         bytes_now;
  logic [HBC_W:0]     hbc_inc;
  logic [7:0]         flip_val;

  assign width_ok    = (pulse_width >= cfg.min_pulse) && (pulse_width < cfg.max_pulse);
  assign is_long     = pulse_width >= cfg.long_threshold;
  assign bytes_now   = 6'(hbc[HBC_W-1:4]);
  assign is_gap      = (pulse_width >= cfg.gap_width) && (bytes_now >= cfg.min_message_bytes);
  assign preamble_ok = fop >= cfg.preamble_needed;
  assign hbc_inc     = (HBC_W+1)'(hbc) + (HBC_W+1)'(1);
  assign overflow    = hbc_inc[HBC_W:4] >= (HBC_W-3)'(BUFFER_BYTES);
  assign in_range    = 7'(byte_index) < 7'(BUFFER_BYTES);
  // A long pulse in the bit-stored phase flips the bit; a second short repeats it.
  assign flip_val    = (phase == PH_BIT) ? (fop ^ 8'd1) : fop;

  always_comb begin
    phase_next = phase;
    case (opcode)
      OP_PULSE: begin
        if (phase != PH_DONE) begin
          if (width_ok) begin
            unique case (phase)
              PH_SEARCH: begin
                if (!is_long) begin
                  phase_next = preamble_ok ? PH_SHORT : PH_SEARCH;
                end
              end
              PH_BIT: begin
                if (is_long) begin
                  phase_next = overflow ? PH_SEARCH : PH_BIT;
                end else begin
                  phase_next = PH_SHORT;
                end
              end
              PH_SHORT: begin
                if (is_long) begin
                  phase_next = PH_SEARCH;
                end else begin
                  phase_next = overflow ? PH_SEARCH : PH_BIT;
                end
              end
              default: phase_next = phase;
            endcase
          end else if (is_gap) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_SEARCH;
          end
        end
      end
      OP_RESTART: phase_next = PH_SEARCH;
      default: phase_next = phase;
    endcase
  end

  always_comb begin
    fop_next = fop;
    hbc_next = hbc;
    req      = '0;
    addr     = hbc[HBC_W-1:4];
    case (opcode)
      OP_PULSE: begin
        if (phase != PH_DONE) begin
          if (width_ok) begin
            unique case (phase)
              PH_SEARCH: begin
                if (is_long) begin
                  if (fop != 8'hFF) begin
                    fop_next = fop + 8'd1;
                  end
                end else begin
                  fop_next = '0;
                  if (!preamble_ok) begin
                    hbc_next = '0;
                  end
                end
              end
              PH_BIT, PH_SHORT: begin
                if ((phase == PH_SHORT) && is_long) begin
                  fop_next = '0;
                  hbc_next = '0;
                end else if ((phase == PH_BIT) && !is_long) begin
                  fop_next = fop;
                end else begin
                  // Only every other half-bit lands in the store.
                  req.shift  = !hbc[0];
                  req.bit_in = |flip_val;
                  fop_next   = overflow ? 8'd0 : flip_val;
                  hbc_next   = overflow ? '0 : hbc_inc[HBC_W-1:0];
                end
              end
              default: fop_next = fop;
            endcase
          end else if (!is_gap) begin
            fop_next = '0;
            hbc_next = '0;
          end
        end
      end
      OP_READ: begin
        req.rd = in_range;
        if (in_range) begin
          addr = AW'(byte_index);
        end
      end
      OP_RESTART: begin
        fop_next = '0;
        hbc_next = '0;
      end
      default: fop_next = fop;
    endcase
  end

  assign status_next.done       = phase_next == PH_DONE;
  assign status_next.byte_count = 6'(hbc_next[HBC_W-1:4]);
  assign status_next.state      = phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      fop   <= '0;
      hbc   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      fop   <= fop_next;
      hbc   <= hbc_next;
    end
  end

  `OOKM_ASSERT(a_restart_clears, accept && (opcode == OP_RESTART) |=>
    (phase == PH_SEARCH) && (hbc == '0) && (fop == '0), "restart did not clear decoder")
  `OOKM_ASSERT(a_done_holds, accept && (opcode == OP_PULSE) && (phase == PH_DONE) |=>
    (phase == PH_DONE) && $stable(hbc), "pulse changed a finished message")
  `OOKM_ASSERT(a_read_keeps_state, accept && (opcode == OP_READ) |=>
    $stable(phase) && $stable(hbc) && $stable(fop), "store read changed decoder state")

endmodule

`default_nettype wire

// File: src/ookm_store.sv
`default_nettype none

module ookm_store
  import ookm_pkg::*;
#(
  parameter int BUFFER_BYTES = 32,
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          accept,
  input  wire store_req_t    req,
  input  wire logic [AW-1:0] addr,
  input  wire logic          s1_move,
  output logic [7:0]         read_byte
);

  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rdata;
  store_req_t    s1_req;
  logic [AW-1:0] s1_addr;
  logic          fwd_hit;
  logic [7:0]    fwd_data;
  logic [7:0]    old_byte;
  logic [7:0]    wr_data;
  logic          wr_en;

  // The read issued with an item misses a write that commits on the same edge,
  // so that write is captured and replaces the stale read data.
  assign old_byte  = fwd_hit ? fwd_data : rdata;
  assign wr_data   = {s1_req.bit_in, old_byte[7:1]};
  assign wr_en     = s1_move && s1_req.shift;
  assign read_byte = s1_req.rd ? old_byte : 8'd0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= wr_data;
    end
    if (accept) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req   <= req;
      s1_addr  <= addr;
      fwd_hit  <= wr_en && (s1_addr == addr);
      fwd_data <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: src/ook_manchester_pulse_decoder.sv
// OOK Manchester pulse-width decoder.
// Input channel (in_valid/in_stall) carries one transaction per command:
// opcode 0 feeds a pulse width, opcode 1 reads a stored byte at byte_index,
// opcode 2 restarts the decoder without touching the byte store.
// Output channel (out_valid/out_stall) returns exactly one transaction per
// input transaction, in order, with the status after that command and, for
// reads, the stored byte (zero for an index beyond the store).
// Each result passes through the memory stage, then the output register.
// Throughput is one transaction per cycle while out_stall is low; the decode
// state lives in registers updated at acceptance, and the byte store is a
// one-port-read, one-port-write memory whose read-modify-write reads at
// acceptance and writes from the memory stage, with a forwarding path.
// When the receiver stalls, the output register holds its transaction and
// one more transaction waits in the memory stage; in_stall rises only when
// both are occupied.
// Synchronous reset empties the pipeline, returns the decoder to searching
// and loads the default thresholds. The byte store is not cleared; its
// entries are defined once a message has written them.
// Configuration writes (cfg_we) take effect on the next edge and belong in
// idle periods.
`default_nettype none
`include "ook_manchester_pulse_decoder_macros.svh"

module ook_manchester_pulse_decoder
  import ookm_pkg::*;
#(
  parameter int BUFFER_BYTES = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             opcode,
  input  wire logic [15:0]            pulse_width,
  input  wire logic [4:0]             byte_index,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        done_res,
  output logic [5:0]                  byte_count,
  output logic [7:0]                  read_data,
  output logic [1:0]                  decoder_state
);

  localparam int AW = $clog2(BUFFER_BYTES);

  cfg_t       cfg;
  status_t    status_next;
  status_t    s1_status;
  store_req_t req;
  logic [AW-1:0] addr;
  logic [7:0] st_read_byte;
  logic       s1_valid;
  logic       s1_move;
  logic       accept;

  // The memory stage drains whenever the output register is empty or being
  // taken, so a new transaction can enter behind it in the same cycle.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PULSE:         cfg.min_pulse         <= cfg_data;
        CFG_LONG_THRESHOLD:    cfg.long_threshold    <= cfg_data;
        CFG_MAX_PULSE:         cfg.max_pulse         <= cfg_data;
        CFG_GAP_WIDTH:         cfg.gap_width         <= cfg_data;
        CFG_PREAMBLE_NEEDED:   cfg.preamble_needed   <= cfg_data[7:0];
        CFG_MIN_MESSAGE_BYTES: cfg.min_message_bytes <= cfg_data[5:0];
        default:               cfg <= cfg;
      endcase
    end
  end

  ookm_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .opcode     (opcode),
    .pulse_width(pulse_width),
    .byte_index (byte_index),
    .status_next(status_next),
    .req        (req),
    .addr       (addr)
  );

  ookm_store #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_store (
    .clk      (clk),
    .accept   (accept),
    .req      (req),
    .addr     (addr),
    .s1_move  (s1_move),
    .read_byte(st_read_byte)
  );

  // Memory stage: status rides along while the store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      done_res      <= s1_status.done;
      byte_count    <= s1_status.byte_count;
      read_data     <= st_read_byte;
      decoder_state <= s1_status.state;
    end
  end

  `OOKM_ASSERT(a_s1_holds, s1_valid && !s1_move |=> s1_valid,
    "memory stage lost a transaction")
  `OOKM_ASSERT(a_accept_fills, accept |=> s1_valid,
    "accepted transaction did not reach the memory stage")
  `OOKM_ASSERT(a_out_loads, s1_move |=> out_valid && (read_data == $past(st_read_byte)),
    "output register did not take the memory stage result")
  `OOKM_ASSERT_ALWAYS(a_reset_empties, rst |=> !s1_valid && !out_valid,
    "pipeline not empty after reset")

endmodule

`default_nettype wire

// File: test/ook_decode_checker.sv
module ook_decode_checker
  import ookm_pkg::*;
#(
  parameter int BUFFER_BYTES = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic [1:0]              opcode,
  input  wire logic [15:0]             pulse_width,
  input  wire logic [4:0]              byte_index,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic                    done_res,
  input  wire logic [5:0]              byte_count,
  input  wire logic [7:0]              read_data,
  input  wire logic [1:0]              decoder_state,
  output int unsigned                  errors,
  output int unsigned                  pending,
  output logic [BUFFER_BYTES-1:0]      filled
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       done;
    logic [5:0] count;
    logic [7:0] data;
    phase_t     state;
  } decode_status_t;

  cfg_t                    thresholds;
  phase_t                  phase;
  logic [7:0]              flip_pre;
  logic [9:0]              half_bits;
  logic [7:0]              byte_store [BUFFER_BYTES];
  logic [3:0]              shift_count [BUFFER_BYTES];
  logic [BUFFER_BYTES-1:0] written;
  decode_status_t          decoded_status_q [$];

  initial errors = 0;

  task automatic clear_decoder();
    phase = PH_SEARCH;
    flip_pre = '0;
    half_bits = '0;
  endtask

  // A byte counts as defined once eight bits have been shifted into it.
  task automatic take_half_bit(logic flip);
    logic [5:0] pos;
    pos = half_bits[9:4];
    flip_pre = flip_pre ^ {7'd0, flip};
    if (!half_bits[0] && pos < BUFFER_BYTES) begin
      byte_store[pos] = {|flip_pre, byte_store[pos][7:1]};
      if (shift_count[pos] < 4'd8) shift_count[pos]++;
      if (shift_count[pos] == 4'd8) written[pos] = 1'b1;
    end
    half_bits++;
    if (half_bits[9:4] >= BUFFER_BYTES) clear_decoder();
    else phase = PH_BIT;
  endtask

  task automatic apply_pulse(logic [15:0] w);
    logic is_long;
    if (phase != PH_DONE) begin
      if (w >= thresholds.min_pulse && w < thresholds.max_pulse) begin
        is_long = (w >= thresholds.long_threshold);
        case (phase)
          PH_SEARCH: begin
            if (is_long) begin
              if (flip_pre != 8'hFF) flip_pre++;
            end else if (flip_pre >= thresholds.preamble_needed) begin
              flip_pre = '0;
              phase = PH_SHORT;
            end else begin
              clear_decoder();
            end
          end
          PH_BIT: begin
            if (is_long) take_half_bit(1'b1);
            else phase = PH_SHORT;
          end
          default: begin
            if (is_long) clear_decoder();
            else take_half_bit(1'b0);
          end
        endcase
      end else if (w >= thresholds.gap_width &&
                   half_bits[9:4] >= thresholds.min_message_bytes) begin
        phase = PH_DONE;
      end else begin
        clear_decoder();
      end
    end
  endtask

  task automatic decode_item(input logic [1:0] op, input logic [15:0] w,
                             input logic [4:0] idx, output decode_status_t st);
    st.data = '0;
    case (op)
      OP_PULSE:   apply_pulse(w);
      OP_READ:    if (idx < BUFFER_BYTES) st.data = byte_store[idx];
      OP_RESTART: clear_decoder();
      default:    ;
    endcase
    st.done  = (phase == PH_DONE);
    st.count = half_bits[9:4];
    st.state = phase;
  endtask

  task automatic compare_status();
    decode_status_t want;
    if (decoded_status_q.size() == 0) begin
      $error("result transaction with no item outstanding");
      errors++;
    end else begin
      want = decoded_status_q.pop_front();
      if (done_res !== want.done) begin
        $error("done_res: expected %0d, got %0d", want.done, done_res);
        errors++;
      end
      if (byte_count !== want.count) begin
        $error("byte_count: expected %0d, got %0d", want.count, byte_count);
        errors++;
      end
      if (read_data !== want.data) begin
        $error("read_data: expected %0d, got %0d", want.data, read_data);
        errors++;
      end
      if (decoder_state !== want.state) begin
        $error("decoder_state: expected %0d, got %0d", want.state, decoder_state);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    decode_status_t st;
    if (rst) begin
      thresholds = CFG_RESET;
      clear_decoder();
      decoded_status_q.delete();
      written = '0;
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        byte_store[i] = '0;
        shift_count[i] = '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_PULSE:         thresholds.min_pulse = cfg_data;
          CFG_LONG_THRESHOLD:    thresholds.long_threshold = cfg_data;
          CFG_MAX_PULSE:         thresholds.max_pulse = cfg_data;
          CFG_GAP_WIDTH:         thresholds.gap_width = cfg_data;
          CFG_PREAMBLE_NEEDED:   thresholds.preamble_needed = cfg_data[7:0];
          CFG_MIN_MESSAGE_BYTES: thresholds.min_message_bytes = cfg_data[5:0];
          default:               ;
        endcase
      end
      if (out_valid && !out_stall) compare_status();
      if (in_valid && !in_stall) begin
        decode_item(opcode, pulse_width, byte_index, st);
        decoded_status_q.push_back(st);
      end
    end
    pending <= decoded_status_q.size();
    filled <= written;
  end

endmodule

// File: test/tb_ook_manchester_pulse_decoder.sv
module tb_ook_manchester_pulse_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import ookm_pkg::*;

  // Opcode 3 has no meaning; the block must only report its status for it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int BYTES = 32;
  // Cycles in which no transaction moves on either channel before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold-off below plus a
  // long random gap, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 64;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             opcode;
  logic [15:0]            pulse_width;
  logic [4:0]             byte_index;
  logic                   out_valid;
  logic                   out_stall;
  logic                   done_res;
  logic [5:0]             byte_count;
  logic [7:0]             read_data;
  logic [1:0]             decoder_state;

  int unsigned errors;
  int unsigned pending;
  logic [BYTES-1:0] filled;

  // Copy of the thresholds last written, used to shape pulse widths.
  cfg_t cur;
  // When set, neither side inserts idle cycles.
  bit   quiet = 1'b0;
  // Asks the receiver process for one long hold-off.
  bit   hold_off_req = 1'b0;
  int   idle_cycles = 0;

  always #1 clk = ~clk;

  ook_manchester_pulse_decoder #(
    .BUFFER_BYTES(BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .pulse_width  (pulse_width),
    .byte_index   (byte_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .done_res     (done_res),
    .byte_count   (byte_count),
    .read_data    (read_data),
    .decoder_state(decoder_state)
  );

  ook_decode_checker #(
    .BUFFER_BYTES(BYTES)
  ) decode_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .pulse_width  (pulse_width),
    .byte_index   (byte_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .done_res     (done_res),
    .byte_count   (byte_count),
    .read_data    (read_data),
    .decoder_state(decoder_state),
    .errors       (errors),
    .pending      (pending),
    .filled       (filled)
  );

  // Idle length for either side: usually none, sometimes a short pause and
  // now and then a long one, so gaps land on every pipeline phase.
  function automatic int pick_idle();
    int r;
    r = int'($urandom_range(0, 99));
    if (quiet || r < 65) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(6, 25));
  endfunction

  // Offers one transaction and returns in the time step in which it was
  // accepted. Valid stays high into the next call unless that call idles,
  // so valid is never dropped and raised again within one step.
  task automatic send(logic [1:0] op, logic [15:0] w, logic [4:0] idx);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    pulse_width <= w;
    byte_index  <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_pulse(logic [15:0] w);
    send(OP_PULSE, w, 5'($urandom_range(0, BYTES - 1)));
  endtask

  task automatic send_restart();
    send(OP_RESTART, 16'($urandom), 5'($urandom));
  endtask

  // Stops offering and waits until every result has come back, then lets
  // the two-stage pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Writes all six registers back to back; only called while idle.
  task automatic apply_settings(cfg_t s);
    write_reg(CFG_MIN_PULSE, s.min_pulse);
    write_reg(CFG_LONG_THRESHOLD, s.long_threshold);
    write_reg(CFG_MAX_PULSE, s.max_pulse);
    write_reg(CFG_GAP_WIDTH, s.gap_width);
    write_reg(CFG_PREAMBLE_NEEDED, {8'd0, s.preamble_needed});
    write_reg(CFG_MIN_MESSAGE_BYTES, {10'd0, s.min_message_bytes});
    cfg_we <= 1'b0;
    cur = s;
  endtask

  // Width generators for the current thresholds. Each one hits the edges of
  // its class often, since off-by-one comparisons are the likely bugs.
  function automatic logic [15:0] short_w();
    case ($urandom_range(0, 5))
      0:       return cur.min_pulse;
      1:       return cur.long_threshold - 16'd1;
      default: return 16'($urandom_range(cur.min_pulse, cur.long_threshold - 16'd1));
    endcase
  endfunction

  function automatic logic [15:0] long_w();
    case ($urandom_range(0, 5))
      0:       return cur.long_threshold;
      1:       return cur.max_pulse - 16'd1;
      default: return 16'($urandom_range(cur.long_threshold, cur.max_pulse - 16'd1));
    endcase
  endfunction

  // A gap must also lie outside the pulse window, which wins on overlap.
  function automatic logic [15:0] gap_w();
    logic [15:0] lo;
    lo = (cur.gap_width > cur.max_pulse) ? cur.gap_width : cur.max_pulse;
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(lo, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] noise_w();
    case ($urandom_range(0, 4))
      0:       return short_w();
      1:       return long_w();
      2:       return gap_w();
      3:       return 16'($urandom_range(0, 16'hFFFF));
      default: begin
        if (cur.min_pulse == 16'd0) return 16'($urandom_range(0, 16'hFFFF));
        return 16'($urandom_range(0, cur.min_pulse - 16'd1));
      end
    endcase
  endfunction

  // Reads only bytes that a message has fully written. The mask from the
  // checker is registered and may lag, but it only grows, so it is always safe.
  task automatic send_reads(int n);
    int idx;
    repeat (n) begin
      if (filled != '0) begin
        do idx = int'($urandom_range(0, BYTES - 1)); while (!filled[idx]);
        send(OP_READ, 16'($urandom), 5'(idx));
      end
    end
  endtask

  // One well-formed Manchester frame: preamble of long pulses, the start
  // short, the first short half-bit, then half-bits made of either one long
  // pulse (the bit flips) or two shorts (the bit repeats). A broken frame
  // instead ends somewhere inside with a long pulse after a first short.
  task automatic send_message(int preamble, int half_bits, bit broken, int long_pct);
    int made;
    int cut;
    bit stop;
    made = 1;
    stop = 1'b0;
    cut  = int'($urandom_range(1, half_bits));
    repeat (preamble) send_pulse(long_w());
    send_pulse(short_w());
    send_pulse(short_w());
    while (made < half_bits && !stop) begin
      if (broken && made == cut) begin
        send_pulse(short_w());
        send_pulse(long_w());
        stop = 1'b1;
      end else begin
        if ($urandom_range(0, 99) < long_pct) begin
          send_pulse(long_w());
        end else begin
          send_pulse(short_w());
          send_pulse(short_w());
        end
        made++;
      end
    end
    if (!broken) send_pulse(gap_w());
  endtask

  // A frame of random length followed by what a host would do with it:
  // maybe a stray pulse while the message is held, some reads, a restart.
  task automatic message_episode(int extra_pre, int lo_bytes, int hi_bytes, int long_pct);
    int half;
    bit broken;
    half = int'($urandom_range(lo_bytes, hi_bytes)) * 16 + int'($urandom_range(0, 15));
    if (half < 1) half = 1;
    if (half > BYTES * 16) half = BYTES * 16;
    broken = ($urandom_range(0, 4) == 0);
    send_message(int'(cur.preamble_needed) + int'($urandom_range(0, extra_pre)), half,
                 broken, long_pct);
    if ($urandom_range(0, 1) == 0) send_pulse(noise_w());
    send_reads(int'($urandom_range(1, 3)));
    send_restart();
  endtask

  // Mostly pulses of any class, with restarts, the unused opcode and reads.
  task automatic send_noise(int n);
    int r;
    repeat (n) begin
      r = int'($urandom_range(0, 19));
      if (r < 13)      send_pulse(noise_w());
      else if (r < 15) send_restart();
      else if (r < 16) send(OP_UNUSED, 16'($urandom), 5'($urandom));
      else if (filled != '0) send_reads(1);
      else             send_pulse(noise_w());
    end
  endtask

  // Receiver side: random stalls, plus one long hold-off on request while
  // the sender keeps offering, which fills the pipeline and pushes back.
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        n = pick_idle();
        out_stall <= (n != 0);
        repeat ((n == 0) ? 1 : n) @(posedge clk);
      end
    end
  end

  // Any cycle that moves a transaction on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_ook_manchester_pulse_decoder: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cfg_t low_cfg;
    cfg_t mid_cfg;
    cfg_t high_cfg;

    // Narrowest possible windows: width 0 is short, 1 is long, 2 and up is
    // a gap, no preamble, and any gap finishes a message.
    low_cfg = '{min_pulse: 16'd0, long_threshold: 16'd1, max_pulse: 16'd2,
                gap_width: 16'd2, preamble_needed: 8'd0, min_message_bytes: 6'd0};
    // Gap threshold inside the pulse window, so widths 600 to 899 are still
    // long pulses and only 900 and above end a message.
    mid_cfg = '{min_pulse: 16'd100, long_threshold: 16'd400, max_pulse: 16'd900,
                gap_width: 16'd600, preamble_needed: 8'd3, min_message_bytes: 6'd2};
    // Widest windows, the full preamble and a byte minimum equal to the store
    // size, which the count never reaches before it wraps, so a gap can never finish here.
    high_cfg = '{min_pulse: 16'd1000, long_threshold: 16'd40000, max_pulse: 16'hFFFF,
                 gap_width: 16'hFFFF, preamble_needed: 8'd255, min_message_bytes: 6'd32};

    cfg_we      = 1'b0;
    cfg_index   = CFG_MIN_PULSE;
    cfg_data    = '0;
    in_valid    = 1'b0;
    opcode      = OP_PULSE;
    pulse_width = '0;
    byte_index  = '0;
    cur         = CFG_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed checks at the reset thresholds: the unused opcode, widths at
    // and around every boundary, a short with too little preamble, a long
    // after it, and an early gap.
    send(OP_UNUSED, 16'hFFFF, 5'd31);
    send_pulse(16'd0);
    send_pulse(16'd199);
    send_pulse(16'd200);
    send_pulse(16'd700);
    send_pulse(16'd1199);
    send_pulse(16'd699);
    send_pulse(16'd1200);
    send_pulse(16'd2499);
    send_pulse(16'd2500);

    // With no byte minimum a gap finishes even while searching; a pulse
    // while done is ignored until a restart. Then one byte of all zero bits,
    // closed by a gap, read back and restarted.
    wait_idle();
    apply_settings(low_cfg);
    send_pulse(16'hFFFF);
    send_pulse(16'd1);
    send(OP_RESTART, 16'h0000, 5'd0);
    send_pulse(16'd0);
    send_pulse(16'd0);
    repeat (15) send_pulse(16'd1);
    send_pulse(16'd2);
    send(OP_READ, 16'hFFFF, 5'd0);
    send(OP_RESTART, 16'hFFFF, 5'd31);

    // Random frames at the low extremes.
    repeat (2) begin
      quiet = ($urandom_range(0, 3) == 0);
      message_episode(3, 0, 2, 60);
    end
    quiet = 1'b0;
    send_noise(12);

    // Mid thresholds. The first frame runs against a long receiver hold-off
    // with the sender offering every cycle.
    wait_idle();
    apply_settings(mid_cfg);
    quiet = 1'b1;
    hold_off_req = 1'b1;
    message_episode(2, 2, 3, 50);
    quiet = ($urandom_range(0, 3) == 0);
    message_episode(2, 1, 2, 50);
    quiet = 1'b0;
    send_noise(12);

    // High extremes: a preamble past the saturation point of the counter,
    // then a short frame whose closing gap comes with too few bytes and
    // resets the decoder.
    wait_idle();
    apply_settings(high_cfg);
    send_message(258, 40, 1'b0, 85);
    send_reads(4);
    send_noise(8);

    // Back to the reset thresholds for a last round of mixed traffic.
    wait_idle();
    apply_settings(CFG_RESET);
    send_noise(12);

    wait_idle();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_ook_manchester_pulse_decoder: PASS");
    end else begin
      $display("tb_ook_manchester_pulse_decoder: FAIL");
    end
    $finish;
  end

endmodule
